/* rtl/aavr_pkg.sv */
package aavr_pkg;

  localparam int COMP_BITS        = 32;
  localparam int DEF_ANGLE_BITS   = 16;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int UNIT_SHIFT       = 30;
  localparam int SUM_W            = 72;
  localparam int CS_W             = 34;
  localparam logic signed [CS_W-1:0] GAIN_INV = 34'sh026DD3B6A;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic signed [CS_W-1:0] atan_lut(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return signed'({2'b00, v});
  endfunction

  // floor((s + 2^29) / 2^30)
  function automatic logic signed [SUM_W-1:0] rnd(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    t = s + (SUM_W'(1) <<< (UNIT_SHIFT - 1));
    return t >>> UNIT_SHIFT;
  endfunction

endpackage

/* rtl/aavr_in_if.sv */
interface aavr_in_if import aavr_pkg::*; #(
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [COMP_BITS-1:0] vec_x;
  logic signed [COMP_BITS-1:0] vec_y;
  logic signed [COMP_BITS-1:0] vec_z;
  logic signed [COMP_BITS-1:0] axis_x;
  logic signed [COMP_BITS-1:0] axis_y;
  logic signed [COMP_BITS-1:0] axis_z;
  logic [ANGLE_BITS-1:0]       turn_angle;

  modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle,
                output ready);
endinterface

/* rtl/aavr_out_if.sv */
interface aavr_out_if import aavr_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [COMP_BITS-1:0] rot_x;
  logic signed [COMP_BITS-1:0] rot_y;
  logic signed [COMP_BITS-1:0] rot_z;
  logic                        zero_axis;
  logic                        clipped;

  modport source (output valid, rot_x, rot_y, rot_z, zero_axis, clipped, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, zero_axis, clipped, output ready);
endinterface

/* rtl/axis_angle_vector_rotate.sv */
// Rotates a vector about an arbitrary axis by a binary angle (Rodrigues' formula),
// Q16.16 components, saturating output with a clip flag and a zero-axis flag.
// Fully pipelined: one item per cycle while the output is not stalled, 73 register
// stages, the last being the result register. The depth is set by the 31-stage
// square root and the 31-stage divider that normalize the axis; the CORDIC for
// sin/cos runs alongside.
// A stall at the output holds the whole pipeline; ready is high whenever the
// output register is empty or being taken.
module axis_angle_vector_rotate import aavr_pkg::*; #(
  parameter int ANGLE_BITS   = DEF_ANGLE_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aavr_in_if.sink    in_i,
  aavr_out_if.source out_o
);

  localparam int ST_LEN  = 2;
  localparam int ST_SHF  = 3;
  localparam int ST_SQ   = 4;
  localparam int ST_SUM  = 5;
  localparam int ST_ROOT = ST_SUM + 31;
  localparam int ST_K    = ST_ROOT + 31;
  localparam int ST_E1   = ST_K + 1;
  localparam int ST_E2   = ST_K + 2;
  localparam int ST_E3   = ST_K + 3;
  localparam int ST_E4   = ST_K + 4;
  localparam int ST_E5   = ST_K + 5;
  localparam int ST_OUT  = ST_K + 6;
  localparam int CS_DONE = CORDIC_STEPS + 2;

  logic en;
  logic vld_q [1:ST_OUT];

  assign en = !vld_q[ST_OUT] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= ST_OUT; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[1] <= in_i.valid;
      for (int s = 2; s <= ST_OUT; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // carried payload
  logic signed [COMP_BITS-1:0] vec_q  [1:ST_E2][3];
  logic                        zero_q [1:ST_E5];
  logic                        neg_q  [1:ST_K-1][3];

  // axis magnitude and normalization
  logic [31:0] m_q   [1:ST_LEN][3];
  logic [31:0] mx_q;
  logic [5:0]  bl_q;
  logic [29:0] mn_q  [ST_SHF:ST_ROOT][3];
  logic [59:0] sq_q  [3];
  logic [61:0] n_q   [ST_SUM:ST_ROOT-1];
  logic [62:0] rt_q  [ST_SUM:ST_ROOT-1];
  logic [31:0] mag_q [ST_ROOT:ST_K-1];
  logic [32:0] rem_q [ST_ROOT+1:ST_K-1][3];
  logic [30:0] quo_q [ST_ROOT+1:ST_K-1][3];
  logic signed [COMP_BITS-1:0] k_q [ST_K:ST_E4][3];

  // cordic
  logic signed [CS_W-1:0] cx_q [1:CORDIC_STEPS+1];
  logic signed [CS_W-1:0] cy_q [1:CORDIC_STEPS+1];
  logic signed [CS_W-1:0] cz_q [1:CORDIC_STEPS+1];
  logic [1:0]             cq_q [1:CORDIC_STEPS+1];
  logic signed [CS_W-1:0] co_q [CS_DONE:ST_E2];
  logic signed [CS_W-1:0] si_q [CS_DONE:ST_E2];

  // rodrigues terms
  logic signed [63:0]    dot_q [3];
  logic signed [63:0]    cra_q [3];
  logic signed [63:0]    crb_q [3];
  logic signed [33:0]    d_q;
  logic signed [33:0]    w_q;
  logic signed [33:0]    c_q [3];
  logic signed [67:0]    pw_q;
  logic signed [65:0]    vc_q [3];
  logic signed [67:0]    cs_q [3];
  logic signed [35:0]    p_q;
  logic signed [SUM_W-1:0] s_q [ST_E4:ST_E5][3];
  logic signed [67:0]    kp_q [3];
  logic signed [COMP_BITS-1:0] rot_q [3];
  logic                  zout_q;
  logic                  clip_q;

  // stage 1: magnitudes, max, zero test
  logic signed [COMP_BITS-1:0] ax_in [3];
  logic signed [COMP_BITS-1:0] v_in  [3];
  logic [31:0] m_in [3];
  logic [31:0] mx_in;
  assign ax_in[0] = in_i.axis_x;
  assign ax_in[1] = in_i.axis_y;
  assign ax_in[2] = in_i.axis_z;
  assign v_in[0]  = in_i.vec_x;
  assign v_in[1]  = in_i.vec_y;
  assign v_in[2]  = in_i.vec_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_in[i] = ax_in[i][COMP_BITS-1] ? 32'(-ax_in[i]) : 32'(ax_in[i]);
    end
    mx_in = m_in[0];
    if (m_in[1] > mx_in) mx_in = m_in[1];
    if (m_in[2] > mx_in) mx_in = m_in[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_q[1][i]   <= m_in[i];
        neg_q[1][i] <= ax_in[i][COMP_BITS-1];
        vec_q[1][i] <= v_in[i];
      end
      mx_q      <= mx_in;
      zero_q[1] <= (mx_in == '0);
    end
  end

  // stage 2: bit length of the largest magnitude
  logic [5:0] bl_d;
  always_comb begin
    bl_d = '0;
    for (int b = 0; b < 32; b++) begin
      if (mx_q[b]) bl_d = 6'(b + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bl_q <= bl_d;
      for (int i = 0; i < 3; i++) m_q[ST_LEN][i] <= m_q[1][i];
    end
  end

  // stage 3: shift so that the largest magnitude has 30 bits
  logic [31:0] sh_d [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (bl_q > 6'd30) begin
        sh_d[i] = m_q[ST_LEN][i] >> (bl_q - 6'd30);
      end else begin
        sh_d[i] = m_q[ST_LEN][i] << (6'd30 - bl_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) mn_q[ST_SHF][i] <= sh_d[i][29:0];
    end
  end

  // stage 4: squares, stage 5: sum
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= 60'(mn_q[ST_SHF][i]) * 60'(mn_q[ST_SHF][i]);
      end
      n_q[ST_SUM]  <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]);
      rt_q[ST_SUM] <= '0;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j <= 30; j++) begin : g_sqrt
    localparam int S = ST_SUM + 1 + j;
    logic [62:0] bitv;
    logic [62:0] t;
    logic        ge;
    logic [61:0] n_d;
    logic [62:0] rt_d;
    assign bitv = 63'(1) << (2 * (30 - j));
    always_comb begin
      t  = rt_q[S-1] + bitv;
      ge = {1'b0, n_q[S-1]} >= t;
      n_d  = ge ? 62'({1'b0, n_q[S-1]} - t) : n_q[S-1];
      rt_d = ge ? (rt_q[S-1] >> 1) + bitv : (rt_q[S-1] >> 1);
    end
    if (j < 30) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (en) begin
          n_q[S]  <= n_d;
          rt_q[S] <= rt_d;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (en) mag_q[S] <= rt_d[31:0];
      end
    end
  end

  for (genvar s = ST_SHF + 1; s <= ST_ROOT; s++) begin : g_mn_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) mn_q[s][i] <= mn_q[s-1][i];
      end
    end
  end

  for (genvar s = ST_ROOT + 1; s <= ST_K - 1; s++) begin : g_mag_dly
    always_ff @(posedge clk_i) begin
      if (en) mag_q[s] <= mag_q[s-1];
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j <= 30; j++) begin : g_div
    localparam int S = ST_ROOT + 1 + j;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [32:0] rin;
      logic        qb;
      logic [32:0] rnew;
      logic [30:0] qnew;
      if (j == 0) begin : g_first
        assign rin  = 33'(mn_q[S-1][i]);
        assign qnew = 31'(qb);
      end else begin : g_next
        assign rin  = {rem_q[S-1][i][31:0], 1'b0};
        assign qnew = {quo_q[S-1][i][29:0], qb};
      end
      assign qb   = rin >= {1'b0, mag_q[S-1]};
      assign rnew = qb ? rin - {1'b0, mag_q[S-1]} : rin;
      if (j < 30) begin : g_mid
        always_ff @(posedge clk_i) begin
          if (en) begin
            rem_q[S][i] <= rnew;
            quo_q[S][i] <= qnew;
          end
        end
      end else begin : g_last
        logic signed [COMP_BITS-1:0] u;
        assign u = signed'(32'(qnew));
        always_ff @(posedge clk_i) begin
          if (en) begin
            if (zero_q[S-1]) begin
              k_q[S][i] <= '0;
            end else begin
              k_q[S][i] <= neg_q[S-1][i] ? -u : u;
            end
          end
        end
      end
    end
  end

  // cordic: quadrant reduction then fixed rotations
  logic [ANGLE_BITS:0]     asum;
  logic [1:0]              q_in;
  logic [ANGLE_BITS-1:0]   r_in;
  assign asum = {1'b0, in_i.turn_angle} + ((ANGLE_BITS+1)'(1) << (ANGLE_BITS - 3));
  assign q_in = asum[ANGLE_BITS-1 -: 2];
  assign r_in = in_i.turn_angle - {q_in, (ANGLE_BITS-2)'(0)};

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[1] <= GAIN_INV;
      cy_q[1] <= '0;
      cz_q[1] <= CS_W'(signed'(r_in)) <<< (32 - ANGLE_BITS);
      cq_q[1] <= q_in;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam int SH = (i < 32) ? i : 31;
    logic signed [CS_W-1:0] dx;
    logic signed [CS_W-1:0] dy;
    assign dx = cy_q[i+1] >>> SH;
    assign dy = cx_q[i+1] >>> SH;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!cz_q[i+1][CS_W-1]) begin
          cx_q[i+2] <= cx_q[i+1] - dx;
          cy_q[i+2] <= cy_q[i+1] + dy;
          cz_q[i+2] <= cz_q[i+1] - atan_lut(SH);
        end else begin
          cx_q[i+2] <= cx_q[i+1] + dx;
          cy_q[i+2] <= cy_q[i+1] - dy;
          cz_q[i+2] <= cz_q[i+1] + atan_lut(SH);
        end
        cq_q[i+2] <= cq_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      case (cq_q[CORDIC_STEPS+1])
        2'd0: begin
          co_q[CS_DONE] <= cx_q[CORDIC_STEPS+1];
          si_q[CS_DONE] <= cy_q[CORDIC_STEPS+1];
        end
        2'd1: begin
          co_q[CS_DONE] <= -cy_q[CORDIC_STEPS+1];
          si_q[CS_DONE] <= cx_q[CORDIC_STEPS+1];
        end
        2'd2: begin
          co_q[CS_DONE] <= -cx_q[CORDIC_STEPS+1];
          si_q[CS_DONE] <= -cy_q[CORDIC_STEPS+1];
        end
        default: begin
          co_q[CS_DONE] <= cy_q[CORDIC_STEPS+1];
          si_q[CS_DONE] <= -cx_q[CORDIC_STEPS+1];
        end
      endcase
    end
  end

  for (genvar s = CS_DONE + 1; s <= ST_E2; s++) begin : g_cs_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        co_q[s] <= co_q[s-1];
        si_q[s] <= si_q[s-1];
      end
    end
  end

  for (genvar s = 2; s <= ST_E2; s++) begin : g_vec_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) vec_q[s][i] <= vec_q[s-1][i];
      end
    end
  end

  for (genvar s = 2; s <= ST_E5; s++) begin : g_zero_dly
    always_ff @(posedge clk_i) begin
      if (en) zero_q[s] <= zero_q[s-1];
    end
  end

  for (genvar s = 2; s <= ST_K - 1; s++) begin : g_neg_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) neg_q[s][i] <= neg_q[s-1][i];
      end
    end
  end

  for (genvar s = ST_K + 1; s <= ST_E4; s++) begin : g_k_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) k_q[s][i] <= k_q[s-1][i];
      end
    end
  end

  // e1: dot and cross products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dot_q[i] <= 64'(k_q[ST_K][i]) * 64'(vec_q[ST_K][i]);
      end
      cra_q[0] <= 64'(k_q[ST_K][1]) * 64'(vec_q[ST_K][2]);
      crb_q[0] <= 64'(k_q[ST_K][2]) * 64'(vec_q[ST_K][1]);
      cra_q[1] <= 64'(k_q[ST_K][2]) * 64'(vec_q[ST_K][0]);
      crb_q[1] <= 64'(k_q[ST_K][0]) * 64'(vec_q[ST_K][2]);
      cra_q[2] <= 64'(k_q[ST_K][0]) * 64'(vec_q[ST_K][1]);
      crb_q[2] <= 64'(k_q[ST_K][1]) * 64'(vec_q[ST_K][0]);
    end
  end

  // e2: round dot and cross, one minus cos
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q <= 34'(rnd(SUM_W'(dot_q[0]) + SUM_W'(dot_q[1]) + SUM_W'(dot_q[2])));
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= 34'(rnd(SUM_W'(cra_q[i]) - SUM_W'(crb_q[i])));
      end
      w_q <= (34'sd1 <<< UNIT_SHIFT) - co_q[ST_E1];
    end
  end

  // e3: d*(1-cos), v*cos, c*sin
  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q <= 68'(d_q) * 68'(w_q);
      for (int i = 0; i < 3; i++) begin
        vc_q[i] <= 66'(vec_q[ST_E2][i]) * 66'(co_q[ST_E2]);
        cs_q[i] <= 68'(c_q[i]) * 68'(si_q[ST_E2]);
      end
    end
  end

  // e4: round p, partial sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= 36'(rnd(SUM_W'(pw_q)));
      for (int i = 0; i < 3; i++) s_q[ST_E4][i] <= SUM_W'(vc_q[i]) + SUM_W'(cs_q[i]);
    end
  end

  // e5: k*p
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        kp_q[i]        <= 68'(k_q[ST_E4][i]) * 68'(p_q);
        s_q[ST_E5][i]  <= s_q[ST_E4][i];
      end
    end
  end

  // e6: final round and saturation
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (COMP_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (COMP_BITS - 1));

  logic signed [SUM_W-1:0]     r_d [3];
  logic signed [COMP_BITS-1:0] rot_d [3];
  logic                        clip_d;
  always_comb begin
    clip_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r_d[i] = rnd(s_q[ST_E5][i] + SUM_W'(kp_q[i]));
      if (r_d[i] > SAT_HI) begin
        rot_d[i] = SAT_HI[COMP_BITS-1:0];
        clip_d   = 1'b1;
      end else if (r_d[i] < SAT_LO) begin
        rot_d[i] = SAT_LO[COMP_BITS-1:0];
        clip_d   = 1'b1;
      end else begin
        rot_d[i] = r_d[i][COMP_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) rot_q[i] <= rot_d[i];
      zout_q <= zero_q[ST_E5];
      clip_q <= clip_d;
    end
  end

  assign out_o.valid     = vld_q[ST_OUT];
  assign out_o.rot_x     = rot_q[0];
  assign out_o.rot_y     = rot_q[1];
  assign out_o.rot_z     = rot_q[2];
  assign out_o.zero_axis = zout_q;
  assign out_o.clipped   = clip_q;

endmodule

/* rtl/aavr_checker.sv */
module aavr_checker import aavr_pkg::*; (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic signed [COMP_BITS-1:0] out_rot_x_i
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rot_x_i))
    else $error("result dropped or changed while stalled");

  // an empty output never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // a held output stalls the whole pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("item taken while pipeline stalled");

  // an item is accepted while the output is valid only if the output is being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && out_valid_i |-> out_ready_i)
    else $error("item accepted while output held");

endmodule

bind axis_angle_vector_rotate aavr_checker u_aavr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_rot_x_i (out_o.rot_x)
);
